FILE: rtl/core/nsf_pkg.sv
package nsf_pkg;

   localparam logic [1:0] MODE_HUNT = 2'd0;
   localparam logic [1:0] MODE_BODY = 2'd1;
   localparam logic [1:0] MODE_SUM  = 2'd2;

   localparam logic [2:0] STATUS_NONE     = 3'd0;
   localparam logic [2:0] STATUS_OK       = 3'd1;
   localparam logic [2:0] STATUS_BAD_SUM  = 3'd2;
   localparam logic [2:0] STATUS_FRAMING  = 3'd3;
   localparam logic [2:0] STATUS_OVERLONG = 3'd4;

   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_GGA   = 3'd1;
   localparam logic [2:0] KIND_GLL   = 3'd2;
   localparam logic [2:0] KIND_GNS   = 3'd3;
   localparam logic [2:0] KIND_GSV   = 3'd4;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2a;
   localparam logic [7:0] CHAR_COMMA  = 8'h2c;
   localparam logic [7:0] CHAR_CR     = 8'h0d;

   localparam logic [23:0] NAME_GGA = 24'h474741;
   localparam logic [23:0] NAME_GLL = 24'h474c4c;
   localparam logic [23:0] NAME_GNS = 24'h474e53;
   localparam logic [23:0] NAME_GSV = 24'h475356;

   localparam logic [4:0] COMMA_MAX = 5'd31;
   localparam logic [6:0] POS_MAX   = 7'd127;
   localparam logic [6:0] MAX_LENGTH_RESET = 7'd127;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  running_xor;
      logic [7:0]  hex_value;
      logic        hex_overflow;
      logic [4:0]  comma_count;
      logic [6:0]  field_position;
      logic [6:0]  sentence_length;
      logic [15:0] talker_chars;
      logic [23:0] type_chars;
   } parse_state_type;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic        payload_flag;
      logic [4:0]  field_index;
      logic [6:0]  char_index;
      logic        sentence_end;
      logic [2:0]  end_status;
      logic [2:0]  sentence_kind;
      logic [15:0] talker_code;
      logic [7:0]  computed_checksum;
      logic [7:0]  received_checksum;
   } result_type;

endpackage

FILE: rtl/core/nsf_parse.sv
module nsf_parse (
   input  nsf_pkg::parse_state_type state_cur,
   input  logic [7:0]               data_byte,
   input  logic [6:0]               max_length,
   output nsf_pkg::parse_state_type state_next,
   output nsf_pkg::result_type      result
);

   logic       hex_valid;
   logic [3:0] hex_nibble;
   logic [7:0] length_inc;
   logic [2:0] kind;

   always_comb begin
      hex_valid  = 1'b1;
      hex_nibble = 4'd0;
      if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
         hex_nibble = data_byte[3:0];
      end else if ((data_byte >= 8'h41 && data_byte <= 8'h46) ||
                   (data_byte >= 8'h61 && data_byte <= 8'h66)) begin
         hex_nibble = data_byte[3:0] + 4'd9;
      end else begin
         hex_valid = 1'b0;
      end
   end

   always_comb begin
      unique case (state_cur.type_chars)
         nsf_pkg::NAME_GGA: kind = nsf_pkg::KIND_GGA;
         nsf_pkg::NAME_GLL: kind = nsf_pkg::KIND_GLL;
         nsf_pkg::NAME_GNS: kind = nsf_pkg::KIND_GNS;
         nsf_pkg::NAME_GSV: kind = nsf_pkg::KIND_GSV;
         default:           kind = nsf_pkg::KIND_OTHER;
      endcase
   end

   assign length_inc = {1'b0, state_cur.sentence_length} + 8'd1;

   always_comb begin
      state_next = state_cur;
      result     = '0;
      result.byte_out = data_byte;

      unique case (state_cur.mode)
         nsf_pkg::MODE_BODY: begin
            if (length_inc > {1'b0, max_length}) begin
               result.sentence_end = 1'b1;
               result.end_status   = nsf_pkg::STATUS_OVERLONG;
               state_next.mode     = nsf_pkg::MODE_HUNT;
            end else begin
               state_next.sentence_length = length_inc[6:0];
               if (data_byte == nsf_pkg::CHAR_STAR) begin
                  state_next.mode = nsf_pkg::MODE_SUM;
               end else begin
                  result.payload_flag    = 1'b1;
                  result.field_index     = state_cur.comma_count;
                  result.char_index      = state_cur.field_position;
                  state_next.running_xor = state_cur.running_xor ^ data_byte;
                  // The talker and sentence name both live in the first field.
                  if (state_cur.comma_count == 5'd0) begin
                     if (state_cur.field_position < 7'd2) begin
                        state_next.talker_chars = {state_cur.talker_chars[7:0], data_byte};
                     end else if (state_cur.field_position < 7'd5) begin
                        state_next.type_chars = {state_cur.type_chars[15:0], data_byte};
                     end
                  end
                  if (data_byte == nsf_pkg::CHAR_COMMA) begin
                     if (state_cur.comma_count < nsf_pkg::COMMA_MAX) begin
                        state_next.comma_count = state_cur.comma_count + 5'd1;
                     end
                     state_next.field_position = 7'd0;
                  end else if (state_cur.field_position < nsf_pkg::POS_MAX) begin
                     state_next.field_position = state_cur.field_position + 7'd1;
                  end
               end
            end
         end
         nsf_pkg::MODE_SUM: begin
            if (data_byte == nsf_pkg::CHAR_CR) begin
               result.sentence_end = 1'b1;
               if (!state_cur.hex_overflow &&
                   state_cur.hex_value == state_cur.running_xor) begin
                  result.end_status    = nsf_pkg::STATUS_OK;
                  result.sentence_kind = kind;
               end else begin
                  result.end_status = nsf_pkg::STATUS_BAD_SUM;
               end
               state_next.mode = nsf_pkg::MODE_HUNT;
            end else if (hex_valid) begin
               if (state_cur.hex_value[7:4] != 4'd0) begin
                  state_next.hex_overflow = 1'b1;
               end
               state_next.hex_value = {state_cur.hex_value[3:0], hex_nibble};
            end else begin
               result.sentence_end = 1'b1;
               result.end_status   = nsf_pkg::STATUS_FRAMING;
               state_next.mode     = nsf_pkg::MODE_HUNT;
            end
         end
         default: begin
            // The spare mode code behaves as hunting.
            if (data_byte == nsf_pkg::CHAR_DOLLAR) begin
               state_next                 = '0;
               state_next.mode            = nsf_pkg::MODE_BODY;
               state_next.sentence_length = 7'd1;
            end else begin
               state_next.mode = nsf_pkg::MODE_HUNT;
            end
         end
      endcase

      if (result.sentence_end) begin
         result.talker_code       = state_cur.talker_chars;
         result.computed_checksum = state_cur.running_xor;
         result.received_checksum = state_cur.hex_value;
      end
   end

endmodule

FILE: rtl/core/nmea_sentence_framer.sv
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   req_data_byte
// rsp_      out        rsp_valid / rsp_stall   rsp_byte_out ... rsp_received_checksum
// csr_      in         csr_wr_en               csr_wr_data (max_length)
//
// One word in and one word out per cycle when neither side stalls; a word passes
// from the input register through the parse to the result register.
// The input register takes a new word while a result waits in the output
// register, so one word is held during an output stall before req_stall rises.
// Reset is synchronous: parser state clears and max_length returns to 127.
module nmea_sentence_framer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_payload_flag,
   output logic [4:0]  rsp_field_index,
   output logic [6:0]  rsp_char_index,
   output logic        rsp_sentence_end,
   output logic [2:0]  rsp_end_status,
   output logic [2:0]  rsp_sentence_kind,
   output logic [15:0] rsp_talker_code,
   output logic [7:0]  rsp_computed_checksum,
   output logic [7:0]  rsp_received_checksum,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_byte_ff;
   logic                     out_valid_ff, out_valid_in;
   nsf_pkg::result_type      result_ff, result_in;
   nsf_pkg::parse_state_type state_ff, state_in;
   logic [6:0]               max_length_ff;
   logic                     req_take;
   logic                     advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   nsf_parse u_parse (
      .state_cur  (state_ff),
      .data_byte  (in_byte_ff),
      .max_length (max_length_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
         max_length_ff <= nsf_pkg::MAX_LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            max_length_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_byte_out          = result_ff.byte_out;
   assign rsp_payload_flag      = result_ff.payload_flag;
   assign rsp_field_index       = result_ff.field_index;
   assign rsp_char_index        = result_ff.char_index;
   assign rsp_sentence_end      = result_ff.sentence_end;
   assign rsp_end_status        = result_ff.end_status;
   assign rsp_sentence_kind     = result_ff.sentence_kind;
   assign rsp_talker_code       = result_ff.talker_code;
   assign rsp_computed_checksum = result_ff.computed_checksum;
   assign rsp_received_checksum = result_ff.received_checksum;

endmodule

FILE: rtl/core/nsf_checker.sv
module nsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_byte_out,
   input logic        rsp_payload_flag,
   input logic [4:0]  rsp_field_index,
   input logic [6:0]  rsp_char_index,
   input logic        rsp_sentence_end,
   input logic [2:0]  rsp_end_status,
   input logic [2:0]  rsp_sentence_kind,
   input logic [15:0] rsp_talker_code,
   input logic [7:0]  rsp_computed_checksum,
   input logic [7:0]  rsp_received_checksum
);

   // A stalled result word must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_out) &&
         $stable(rsp_end_status))
      else $error("result word changed while stalled");

   // Index fields carry nothing outside the payload.
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_flag |-> rsp_field_index == 5'd0 && rsp_char_index == 7'd0)
      else $error("index fields set outside the payload");

   // Summary fields appear only on the word that ends a sentence.
   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sentence_end |-> rsp_end_status == nsf_pkg::STATUS_NONE &&
         rsp_talker_code == 16'd0 && rsp_computed_checksum == 8'd0 &&
         rsp_received_checksum == 8'd0)
      else $error("sentence summary outside a sentence end");

   // An ending word carries a real status and is never payload.
   a_end_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sentence_end |-> !rsp_payload_flag &&
         rsp_end_status != nsf_pkg::STATUS_NONE)
      else $error("sentence end without status");

   // The sentence kind is reported only on a good checksum.
   a_kind_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_status != nsf_pkg::STATUS_OK |->
         rsp_sentence_kind == nsf_pkg::KIND_OTHER)
      else $error("sentence kind without a good checksum");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_stall             (rsp_stall),
   .rsp_byte_out          (rsp_byte_out),
   .rsp_payload_flag      (rsp_payload_flag),
   .rsp_field_index       (rsp_field_index),
   .rsp_char_index        (rsp_char_index),
   .rsp_sentence_end      (rsp_sentence_end),
   .rsp_end_status        (rsp_end_status),
   .rsp_sentence_kind     (rsp_sentence_kind),
   .rsp_talker_code       (rsp_talker_code),
   .rsp_computed_checksum (rsp_computed_checksum),
   .rsp_received_checksum (rsp_received_checksum)
);
